// File: rtl/sdl_pkg.sv
package sdl_pkg;

    localparam int FRAME_PIXELS_DEF = 128;
    localparam int EDGE_MARGIN_DEF  = 2;
    localparam int SAMPLE_BITS_DEF  = 10;

    localparam int THRESH_W    = 10;
    localparam int MARGIN_W    = 4;
    localparam int POS_W       = 7;
    localparam int COUNT_W     = 7;
    localparam int COUNT_LIMIT = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [THRESH_W-1:0] BLACK_RESET  = 10'd200;
    localparam logic [THRESH_W-1:0] WHITE_RESET  = 10'd800;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 4'd4;

    typedef enum logic [1:0] {
        REG_BLACK_THRESHOLD = 2'd0,
        REG_WHITE_THRESHOLD = 2'd1,
        REG_GAP_LIMIT       = 2'd2,
        REG_UNUSED          = 2'd3
    } sdl_reg_t;

    typedef enum logic [1:0] {
        COLOUR_NONE  = 2'd0,
        COLOUR_BLACK = 2'd1,
        COLOUR_WHITE = 2'd2
    } sdl_colour_t;

    typedef enum logic {
        KIND_LINE    = 1'b0,
        KIND_SUMMARY = 1'b1
    } sdl_kind_t;

    typedef struct packed {
        logic [THRESH_W-1:0] black_threshold;
        logic [THRESH_W-1:0] white_threshold;
        logic [MARGIN_W-1:0] gap_limit;
    } sdl_cfg_t;

    // One queued event: a line result, a summary result, or both (line first).
    typedef struct packed {
        logic               has_line;
        logic               has_summary;
        logic [POS_W-1:0]   line_position;
        logic [COUNT_W-1:0] line_count;
    } sdl_event_t;

endpackage

// File: rtl/scanline_dark_line_locator.sv
// Dark line locator for a line-scan sensor. Each transfer on the input side
// is one converter sample; frame_start marks pixel 0, otherwise the pixel
// index wraps after FRAME_PIXELS samples. Pixels are sorted black / white /
// unknown against the two thresholds, pixels within EDGE_MARGIN of either end
// are ignored, and every dark run that closes gives one line result (kind 0)
// with its centre index. The last pixel of a frame gives a summary result
// (kind 1) with the line count, saturating at 64. last flags the final
// result caused by a pixel. Rate: one pixel per clock while full is low. The
// classifier updates its tracking state in the cycle the sample is taken
// and posts any results as one event into a 4-entry queue; the result side
// drains that queue at one result per pop, so an event carrying a line plus
// the frame summary takes two pops. full rises only when the queue holds
// four undelivered events. Registers (APB, 32-bit data): 0x0 black
// threshold, 0x4 white threshold, 0x8 gap limit; write them only while
// the block is idle.
module scanline_dark_line_locator #(
    parameter int FRAME_PIXELS = sdl_pkg::FRAME_PIXELS_DEF,
    parameter int EDGE_MARGIN  = sdl_pkg::EDGE_MARGIN_DEF,
    parameter int SAMPLE_BITS  = sdl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdl_pkg::ADDR_W-1:0]  paddr,
    input  logic [sdl_pkg::DATA_W-1:0]  pwdata,
    output logic [sdl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // pixel input
    input  logic                        push,
    output logic                        full,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  logic                        frame_start,
    // results
    output logic                        empty,
    input  logic                        pop,
    output logic                        kind,
    output logic [sdl_pkg::POS_W-1:0]   line_position,
    output logic [sdl_pkg::COUNT_W-1:0] line_count,
    output logic                        last
);

    sdl_pkg::sdl_cfg_t   cfg_reg;
    sdl_pkg::sdl_reg_t   reg_sel;
    logic                cfg_wr;
    logic                accept;
    logic                evt_valid;
    sdl_pkg::sdl_event_t evt, head;
    logic                head_empty, head_pop;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_sel = sdl_pkg::sdl_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            sdl_pkg::REG_BLACK_THRESHOLD:
                prdata = sdl_pkg::DATA_W'(cfg_reg.black_threshold);
            sdl_pkg::REG_WHITE_THRESHOLD:
                prdata = sdl_pkg::DATA_W'(cfg_reg.white_threshold);
            sdl_pkg::REG_GAP_LIMIT:
                prdata = sdl_pkg::DATA_W'(cfg_reg.gap_limit);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.black_threshold <= sdl_pkg::BLACK_RESET;
            cfg_reg.white_threshold <= sdl_pkg::WHITE_RESET;
            cfg_reg.gap_limit       <= sdl_pkg::MARGIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                sdl_pkg::REG_BLACK_THRESHOLD:
                    cfg_reg.black_threshold <= pwdata[sdl_pkg::THRESH_W-1:0];
                sdl_pkg::REG_WHITE_THRESHOLD:
                    cfg_reg.white_threshold <= pwdata[sdl_pkg::THRESH_W-1:0];
                sdl_pkg::REG_GAP_LIMIT:
                    cfg_reg.gap_limit <= pwdata[sdl_pkg::MARGIN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---------------- front: classify and track ----------------
    // A sample is taken whenever push is high and the event queue has room.
    assign accept = push && !full;

    sdl_front #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .EDGE_MARGIN  (EDGE_MARGIN),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .sample      (sample),
        .frame_start (frame_start),
        .cfg         (cfg_reg),
        .evt_valid   (evt_valid),
        .evt         (evt)
    );

    // ---------------- event queue between the two sides ----------------
    sdl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (evt_valid),
        .wr_data (evt),
        .full    (full),
        .rd      (head_pop),
        .rd_data (head),
        .empty   (head_empty)
    );

    // ---------------- back: one result per transfer ----------------
    sdl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_empty    (head_empty),
        .head_pop      (head_pop),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .line_position (line_position),
        .line_count    (line_count),
        .last          (last)
    );

endmodule

// File: rtl/sdl_front.sv
module sdl_front #(
    parameter int FRAME_PIXELS = sdl_pkg::FRAME_PIXELS_DEF,
    parameter int EDGE_MARGIN  = sdl_pkg::EDGE_MARGIN_DEF,
    parameter int SAMPLE_BITS  = sdl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   frame_start,
    input  sdl_pkg::sdl_cfg_t      cfg,
    output logic                   evt_valid,
    output sdl_pkg::sdl_event_t    evt
);

    localparam int IDX_W  = $clog2(FRAME_PIXELS);
    localparam int CMP_W  = (SAMPLE_BITS > sdl_pkg::THRESH_W) ? SAMPLE_BITS : sdl_pkg::THRESH_W;
    localparam int DIF_W  = IDX_W + sdl_pkg::MARGIN_W;
    localparam bit WIN_EN = FRAME_PIXELS > 2 * EDGE_MARGIN;
    localparam int WIN_LO = EDGE_MARGIN;
    localparam int WIN_HI = FRAME_PIXELS - EDGE_MARGIN - 1;
    localparam logic [IDX_W-1:0] WIN_LO_IDX = IDX_W'(WIN_LO);
    localparam logic [IDX_W-1:0] WIN_HI_IDX = IDX_W'(WIN_HI);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_PIXELS - 1);
    localparam logic [sdl_pkg::COUNT_W-1:0] LIMIT = sdl_pkg::COUNT_W'(sdl_pkg::COUNT_LIMIT);

    logic [IDX_W-1:0]            pixel_counter_reg, pixel_counter_next;
    sdl_pkg::sdl_colour_t        last_colour_reg, last_colour_next;
    logic [IDX_W-1:0]            last_index_reg, last_index_next;
    logic                        run_open_reg, run_open_next;
    logic [IDX_W-1:0]            run_start_reg, run_start_next;
    logic [sdl_pkg::COUNT_W-1:0] lines_found_reg, lines_found_next;

    logic [IDX_W-1:0]            idx;
    logic                        clear;
    sdl_pkg::sdl_colour_t        last_colour_eff, colour;
    logic [IDX_W-1:0]            last_index_eff, run_start_eff;
    logic                        run_open_eff;
    logic [sdl_pkg::COUNT_W-1:0] lines_eff;
    logic                        in_window, near, open_run, white_close, edge_close;
    logic [IDX_W-1:0]            diff, run_end;
    logic [IDX_W:0]              pos_sum;
    logic [IDX_W+sdl_pkg::POS_W-1:0] centre_ext;

    always_comb
    begin
        idx   = frame_start ? '0 : pixel_counter_reg;
        clear = (idx == '0);

        last_colour_eff = clear ? sdl_pkg::COLOUR_NONE : last_colour_reg;
        last_index_eff  = clear ? '0 : last_index_reg;
        run_open_eff    = clear ? 1'b0 : run_open_reg;
        run_start_eff   = clear ? '0 : run_start_reg;
        lines_eff       = clear ? '0 : lines_found_reg;

        in_window = WIN_EN && (idx >= WIN_LO_IDX) && (idx <= WIN_HI_IDX);

        // black is tested first when thresholds overlap
        if (CMP_W'(sample) < CMP_W'(cfg.black_threshold))
            colour = sdl_pkg::COLOUR_BLACK;
        else if (CMP_W'(sample) > CMP_W'(cfg.white_threshold))
            colour = sdl_pkg::COLOUR_WHITE;
        else
            colour = sdl_pkg::COLOUR_NONE;

        diff = idx - last_index_eff;
        near = (last_colour_eff != sdl_pkg::COLOUR_NONE) && (idx >= last_index_eff)
               && (DIF_W'(diff) <= DIF_W'(cfg.gap_limit));

        open_run = in_window && (colour == sdl_pkg::COLOUR_BLACK) && !run_open_eff
                   && ((idx == WIN_LO_IDX)
                       || ((last_colour_eff == sdl_pkg::COLOUR_WHITE) && near));
        white_close = in_window && (colour == sdl_pkg::COLOUR_WHITE) && run_open_eff
                      && (last_colour_eff == sdl_pkg::COLOUR_BLACK) && near;

        run_start_next = open_run ? idx : run_start_eff;
        run_open_next  = (run_open_eff || open_run) && !white_close;
        edge_close     = in_window && run_open_next && (idx == WIN_HI_IDX);
        if (edge_close)
            run_open_next = 1'b0;

        run_end    = white_close ? last_index_eff : idx;
        pos_sum    = {1'b0, run_start_next} + {1'b0, run_end};
        centre_ext = {{sdl_pkg::POS_W{1'b0}}, pos_sum[IDX_W:1]};

        lines_found_next = lines_eff;
        if ((white_close || edge_close) && (lines_eff < LIMIT))
            lines_found_next = lines_eff + 1'b1;

        if (in_window && (colour != sdl_pkg::COLOUR_NONE))
        begin
            last_colour_next = colour;
            last_index_next  = idx;
        end
        else
        begin
            last_colour_next = last_colour_eff;
            last_index_next  = last_index_eff;
        end

        pixel_counter_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;

        evt.has_line      = white_close || edge_close;
        evt.has_summary   = (idx == LAST_IDX);
        evt.line_position = centre_ext[sdl_pkg::POS_W-1:0];
        evt.line_count    = lines_found_next;
        evt_valid         = accept && (evt.has_line || evt.has_summary);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_counter_reg <= '0;
            last_colour_reg   <= sdl_pkg::COLOUR_NONE;
            last_index_reg    <= '0;
            run_open_reg      <= 1'b0;
            run_start_reg     <= '0;
            lines_found_reg   <= '0;
        end
        else if (accept)
        begin
            pixel_counter_reg <= pixel_counter_next;
            last_colour_reg   <= last_colour_next;
            last_index_reg    <= last_index_next;
            run_open_reg      <= run_open_next;
            run_start_reg     <= run_start_next;
            lines_found_reg   <= lines_found_next;
        end
    end

endmodule

// File: rtl/sdl_queue.sv
module sdl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  sdl_pkg::sdl_event_t wr_data,
    output logic                full,
    input  logic                rd,
    output sdl_pkg::sdl_event_t rd_data,
    output logic                empty
);

    localparam int PTR_W = $clog2(sdl_pkg::QUEUE_DEPTH);

    sdl_pkg::sdl_event_t entry_reg [sdl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             do_wr, do_rd;

    assign full    = (fill_reg == (PTR_W+1)'(sdl_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_wr && !do_rd)
            fill_next = fill_reg + 1'b1;
        else if (do_rd && !do_wr)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fill_reg <= fill_next;
        end
    end

endmodule

// File: rtl/sdl_back.sv
module sdl_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sdl_pkg::sdl_event_t        head,
    input  logic                       head_empty,
    output logic                       head_pop,
    output logic                       empty,
    input  logic                       pop,
    output logic                       kind,
    output logic [sdl_pkg::POS_W-1:0]  line_position,
    output logic [sdl_pkg::COUNT_W-1:0] line_count,
    output logic                       last
);

    // set once the line half of a line-plus-summary event has been transferred
    logic phase_reg, phase_next;
    logic show_line, xfer;

    always_comb
    begin
        show_line     = head.has_line && !phase_reg;
        empty         = head_empty;
        xfer          = pop && !head_empty;
        kind          = show_line ? sdl_pkg::KIND_LINE : sdl_pkg::KIND_SUMMARY;
        line_position = show_line ? head.line_position : '0;
        line_count    = head.line_count;
        last          = !(show_line && head.has_summary);
        head_pop      = xfer && last;
        phase_next    = phase_reg;
        if (xfer)
            phase_next = !last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else
            phase_reg <= phase_next;
    end

endmodule
